>>> design/banned_word_masking_filter_top_defines.svh
// assertion macros for the banned word masking filter
`ifndef BANNED_WORD_MASKING_FILTER_TOP_DEFINES_SVH
`define BANNED_WORD_MASKING_FILTER_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BWMF_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define BWMF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

>>> design/bwmf_pkg.sv
// ----------------------------------------------------------------------------
// bwmf_pkg
// shared types, constants and the case-folding function of the banned word masking filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bwmf_pkg;
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_PATTERN = 2'd1;
	localparam logic [1:0] CMD_MESSAGE = 2'd2;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] MASK_CHAR   = 8'h2A;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MLEN,
		ST_MRD,
		ST_MCMP,
		ST_SPACE,
		ST_EMIT,
		ST_CLOSE
	} state_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       end_of_message;
		logic       banned_found;
		logic       overflow_flag;
	} out_item_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction
endpackage
`default_nettype wire

>>> design/bwmf_if.sv
// ----------------------------------------------------------------------------
// bwmf_in_if / bwmf_out_if
// valid/ready channels of the filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface bwmf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, cmd, data_byte, last_byte, input ready);
	modport sink (input valid, cmd, data_byte, last_byte, output ready);
endinterface

interface bwmf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       end_of_message;
	logic       banned_found;
	logic       overflow_flag;
	modport source (output valid, out_char, char_valid, end_of_message,
		banned_found, overflow_flag, input ready);
	modport sink (input valid, out_char, char_valid, end_of_message,
		banned_found, overflow_flag, output ready);
endinterface
`default_nettype wire

>>> design/bwmf_pat_mem.sv
// ----------------------------------------------------------------------------
// bwmf_pat_mem
// pattern byte store and pattern length store, both with registered reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bwmf_pat_mem #(
	parameter int NP = 64,
	parameter int PM = 32,
	parameter int AW = 11,
	parameter int PW = 6,
	parameter int LW = 6
) (
	input  wire logic          clk,
	input  wire logic          byte_we,
	input  wire logic [AW-1:0] byte_waddr,
	input  wire logic [7:0]    byte_wdata,
	input  wire logic [AW-1:0] byte_raddr,
	output logic      [7:0]    byte_rdata,
	input  wire logic          len_we,
	input  wire logic [PW-1:0] len_waddr,
	input  wire logic [LW-1:0] len_wdata,
	input  wire logic [PW-1:0] len_raddr,
	output logic      [LW-1:0] len_rdata
);
	logic [7:0]    byte_mem [NP*PM];
	logic [LW-1:0] len_mem  [NP];

	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_waddr] <= byte_wdata;
		end
		byte_rdata <= byte_mem[byte_raddr];
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_waddr] <= len_wdata;
		end
		len_rdata <= len_mem[len_raddr];
	end
endmodule
`default_nettype wire

>>> design/banned_word_masking_filter_top.sv
// ----------------------------------------------------------------------------
// banned_word_masking_filter_top
// masks message words that contain a stored pattern, pattern table in memory
// ----------------------------------------------------------------------------
// channel | dir | fields
// in_ch   | in  | cmd, data_byte, last_byte
// out_ch  | out | out_char, char_valid, end_of_message, banned_found,
//         |     | overflow_flag
// clear and pattern items and plain message bytes are taken in the idle state
// a word end searches the table pattern by pattern: read the length, then
// compare the word with it byte by byte at each offset (an empty table skips this)
// then the separator slot, one item per word character and the closing item,
// each held while out_ch is not ready; in_ch waits meanwhile
// reset clears the state, counters and flags only; memories hold undefined data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "banned_word_masking_filter_top_defines.svh"
module banned_word_masking_filter_top #(
	parameter int NUM_PATTERNS = 64,
	parameter int PATTERN_MAX  = 32,
	parameter int WORD_MAX     = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	bwmf_in_if.sink    in_ch,
	bwmf_out_if.source out_ch
);
	localparam int PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
	localparam int CW = $clog2(NUM_PATTERNS + 1);
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int WW = $clog2(WORD_MAX + 1);
	localparam int BW = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
	localparam int AW = $clog2(NUM_PATTERNS * PATTERN_MAX);

	bwmf_pkg::state_t state_q, state_d;
	logic [CW-1:0] pcount_q;
	logic [LW-1:0] load_len_q;
	logic [7:0]    wbuf_q [WORD_MAX];
	logic [WW-1:0] wlen_q;
	logic          first_q, banned_q, ovf_q, masked_q, close_q;
	logic [PW-1:0] p_q;
	logic [WW-1:0] off_q, k_q, emit_q;
	logic [LW-1:0] plen_q;
	bwmf_pkg::out_item_t obuf_q;
	logic          ovalid_q;

	logic          byte_we, len_we;
	logic [AW-1:0] byte_waddr, byte_raddr;
	logic [7:0]    byte_rdata;
	logic [LW-1:0] len_rdata;
	logic          accept, is_full, pat_cmd, pat_store;
	logic          obuf_free;
	logic [AW:0]   waddr_w, raddr_w;
	logic [WW:0]   pos_w;

	assign obuf_free = !ovalid_q || out_ch.ready;
	assign in_ch.ready = (state_q == bwmf_pkg::ST_IDLE);
	assign accept = in_ch.valid && in_ch.ready;
	assign is_full = pcount_q >= CW'(NUM_PATTERNS);
	assign pat_cmd = accept && in_ch.cmd == bwmf_pkg::CMD_PATTERN;
	assign pat_store = pat_cmd && in_ch.data_byte != 8'd0 && !is_full
		&& load_len_q < LW'(PATTERN_MAX);
	assign waddr_w = (AW+1)'(pcount_q) * (AW+1)'(PATTERN_MAX) + (AW+1)'(load_len_q);
	assign raddr_w = (AW+1)'(p_q) * (AW+1)'(PATTERN_MAX) + (AW+1)'(k_q);
	assign byte_we = pat_store;
	assign byte_waddr = waddr_w[AW-1:0];
	assign byte_raddr = raddr_w[AW-1:0];
	assign len_we = pat_cmd && in_ch.last_byte && !is_full;
	assign pos_w = (WW+1)'(off_q) + (WW+1)'(k_q);

	bwmf_pat_mem #(
		.NP(NUM_PATTERNS), .PM(PATTERN_MAX), .AW(AW), .PW(PW), .LW(LW)
	) u_mem (
		.clk(clk),
		.byte_we(byte_we), .byte_waddr(byte_waddr),
		.byte_wdata(bwmf_pkg::to_lower(in_ch.data_byte)),
		.byte_raddr(byte_raddr), .byte_rdata(byte_rdata),
		.len_we(len_we), .len_waddr(pcount_q[PW-1:0]),
		.len_wdata(pat_store ? load_len_q + LW'(1) : load_len_q),
		.len_raddr(p_q), .len_rdata(len_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bwmf_pkg::ST_IDLE: begin
				if (accept && in_ch.cmd == bwmf_pkg::CMD_MESSAGE
					&& (in_ch.data_byte == bwmf_pkg::SPACE_CHAR || in_ch.last_byte)) begin
					if (wlen_q != '0 || (in_ch.data_byte != bwmf_pkg::SPACE_CHAR
						&& in_ch.data_byte != 8'd0)) begin
						state_d = (pcount_q == '0) ? bwmf_pkg::ST_SPACE : bwmf_pkg::ST_MLEN;
					end else begin
						state_d = in_ch.last_byte ? bwmf_pkg::ST_CLOSE : bwmf_pkg::ST_IDLE;
					end
				end
			end
			bwmf_pkg::ST_MLEN: state_d = bwmf_pkg::ST_MRD;
			bwmf_pkg::ST_MRD: begin
				if (len_rdata == '0) begin
					state_d = bwmf_pkg::ST_SPACE;
				end else if ((WW+1)'(len_rdata) > (WW+1)'(wlen_q)) begin
					state_d = ((CW)'(p_q) + CW'(1) >= pcount_q) ? bwmf_pkg::ST_SPACE
						: bwmf_pkg::ST_MLEN;
				end else begin
					state_d = bwmf_pkg::ST_MCMP;
				end
			end
			bwmf_pkg::ST_MCMP: begin
				if (byte_rdata == bwmf_pkg::to_lower(wbuf_q[pos_w[BW-1:0]])) begin
					state_d = ((LW+1)'(k_q) + (LW+1)'(1) == (LW+1)'(plen_q))
						? bwmf_pkg::ST_SPACE : bwmf_pkg::ST_MRD;
				end else if ((WW+1)'(off_q) + (WW+1)'(plen_q) + (WW+1)'(1)
					> (WW+1)'(wlen_q)) begin
					state_d = ((CW)'(p_q) + CW'(1) >= pcount_q) ? bwmf_pkg::ST_SPACE
						: bwmf_pkg::ST_MLEN;
				end else begin
					state_d = bwmf_pkg::ST_MRD;
				end
			end
			bwmf_pkg::ST_SPACE: if (obuf_free) state_d = bwmf_pkg::ST_EMIT;
			bwmf_pkg::ST_EMIT: begin
				if (obuf_free && emit_q + WW'(1) == wlen_q) begin
					state_d = close_q ? bwmf_pkg::ST_CLOSE : bwmf_pkg::ST_IDLE;
				end
			end
			bwmf_pkg::ST_CLOSE: if (obuf_free) state_d = bwmf_pkg::ST_IDLE;
			default: state_d = bwmf_pkg::ST_IDLE;
		endcase
	end

	// datapath and outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bwmf_pkg::ST_IDLE;
			pcount_q <= '0;
			load_len_q <= '0;
			wlen_q <= '0;
			first_q <= 1'b1;
			banned_q <= 1'b0;
			ovf_q <= 1'b0;
			masked_q <= 1'b0;
			close_q <= 1'b0;
			ovalid_q <= 1'b0;
			p_q <= '0;
			off_q <= '0;
			k_q <= '0;
			emit_q <= '0;
			plen_q <= '0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ch.ready && state_q != bwmf_pkg::ST_SPACE
				&& state_q != bwmf_pkg::ST_EMIT && state_q != bwmf_pkg::ST_CLOSE) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				bwmf_pkg::ST_IDLE: begin
					masked_q <= (pcount_q != '0) ? 1'b0 : 1'b0;
					p_q <= '0;
					off_q <= '0;
					k_q <= '0;
					emit_q <= '0;
					if (accept) begin
						case (in_ch.cmd)
							bwmf_pkg::CMD_CLEAR: begin
								pcount_q <= '0;
								load_len_q <= '0;
							end
							bwmf_pkg::CMD_PATTERN: begin
								if ((in_ch.data_byte != 8'd0 && !pat_store)
									|| (in_ch.last_byte && is_full)) ovf_q <= 1'b1;
								if (in_ch.last_byte) begin
									load_len_q <= '0;
									if (!is_full) pcount_q <= pcount_q + CW'(1);
								end else if (pat_store) begin
									load_len_q <= load_len_q + LW'(1);
								end
							end
							bwmf_pkg::CMD_MESSAGE: begin
								close_q <= in_ch.last_byte;
								if (in_ch.data_byte != bwmf_pkg::SPACE_CHAR
									&& in_ch.data_byte != 8'd0) begin
									if (wlen_q < WW'(WORD_MAX)) begin
										wbuf_q[wlen_q[BW-1:0]] <= in_ch.data_byte;
										wlen_q <= wlen_q + WW'(1);
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
							default: ;
						endcase
					end
				end
				bwmf_pkg::ST_MLEN: begin
					off_q <= '0;
					k_q <= '0;
				end
				bwmf_pkg::ST_MRD: begin
					plen_q <= len_rdata;
					if (len_rdata == '0) masked_q <= 1'b1;
					else if ((WW+1)'(len_rdata) > (WW+1)'(wlen_q)) p_q <= p_q + PW'(1);
				end
				bwmf_pkg::ST_MCMP: begin
					if (byte_rdata == bwmf_pkg::to_lower(wbuf_q[pos_w[BW-1:0]])) begin
						if ((LW+1)'(k_q) + (LW+1)'(1) == (LW+1)'(plen_q)) masked_q <= 1'b1;
						else k_q <= k_q + WW'(1);
					end else if ((WW+1)'(off_q) + (WW+1)'(plen_q) + (WW+1)'(1)
						> (WW+1)'(wlen_q)) begin
						p_q <= p_q + PW'(1);
					end else begin
						off_q <= off_q + WW'(1);
						k_q <= '0;
					end
				end
				bwmf_pkg::ST_SPACE: begin
					if (obuf_free) begin
						if (masked_q) banned_q <= 1'b1;
						first_q <= 1'b0;
						ovalid_q <= !first_q;
						obuf_q <= '{bwmf_pkg::SPACE_CHAR, 1'b1, 1'b0, 1'b0, 1'b0};
					end
				end
				bwmf_pkg::ST_EMIT: begin
					if (obuf_free) begin
						ovalid_q <= 1'b1;
						obuf_q <= '{masked_q ? bwmf_pkg::MASK_CHAR : wbuf_q[emit_q[BW-1:0]],
							1'b1, 1'b0, 1'b0, 1'b0};
						emit_q <= emit_q + WW'(1);
						if (emit_q + WW'(1) == wlen_q) wlen_q <= '0;
					end
				end
				bwmf_pkg::ST_CLOSE: begin
					if (obuf_free) begin
						ovalid_q <= 1'b1;
						obuf_q <= '{8'd0, 1'b0, 1'b1, banned_q, ovf_q};
						first_q <= 1'b1;
						banned_q <= 1'b0;
						ovf_q <= 1'b0;
						wlen_q <= '0;
						close_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.out_char = obuf_q.out_char;
	assign out_ch.char_valid = obuf_q.char_valid;
	assign out_ch.end_of_message = obuf_q.end_of_message;
	assign out_ch.banned_found = obuf_q.banned_found;
	assign out_ch.overflow_flag = obuf_q.overflow_flag;

	`BWMF_ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, pcount_q <= CW'(NUM_PATTERNS))
	`BWMF_ASSERT_IMPL(a_word_range, clk, arst_n, 1'b1, wlen_q <= WW'(WORD_MAX))
	`BWMF_ASSERT_NEXT(a_close_resets, clk, arst_n,
		state_q == bwmf_pkg::ST_CLOSE && obuf_free, first_q && !banned_q && !ovf_q)
	`BWMF_ASSERT_IMPL(a_busy_no_ready, clk, arst_n,
		state_q != bwmf_pkg::ST_IDLE, !in_ch.ready)
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banned word masking filter. It loads pattern
// tables and streams messages through the input channel. A scoreboard keeps
// its own copy of the table and of the word in progress, and predicts every
// output item. The output channel is checked item by item. Both channels
// idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int NPAT = 64;
	localparam int PMAX = 32;
	localparam int WMAX = 32;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class mask_scoreboard;
		logic [7:0] pat_mem[NPAT][PMAX];
		int pat_len[NPAT];
		int pat_cnt;
		int load_len;
		logic [7:0] word_buf[WMAX];
		int word_len;
		bit first_word;
		bit banned_flag;
		bit ovf_flag;
		bwmf_pkg::out_item_t expected_q[$];
		int n_in;
		int n_out;
		int n_masked;
		int n_msgs;

		function new();
			pat_cnt = 0;
			load_len = 0;
			word_len = 0;
			first_word = 1;
			banned_flag = 0;
			ovf_flag = 0;
			n_in = 0;
			n_out = 0;
			n_masked = 0;
			n_msgs = 0;
		endfunction

		function logic [7:0] fold_case(logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
		endfunction

		function bit word_hit();
			int k;
			for (int p = 0; p < pat_cnt; p++) begin
				if (pat_len[p] == 0) begin
					return 1;
				end
				for (int o = 0; o + pat_len[p] <= word_len; o++) begin
					for (k = 0; k < pat_len[p]; k++) begin
						if (fold_case(word_buf[o + k]) != pat_mem[p][k]) begin
							break;
						end
					end
					if (k == pat_len[p]) begin
						return 1;
					end
				end
			end
			return 0;
		endfunction

		function void push_char(logic [7:0] c);
			bwmf_pkg::out_item_t it;
			it = '0;
			it.out_char = c;
			it.char_valid = 1'b1;
			expected_q.push_back(it);
		endfunction

		function void emit_word();
			bit hit;
			if (word_len == 0) begin
				return;
			end
			hit = word_hit();
			if (hit) begin
				banned_flag = 1;
				n_masked++;
			end
			if (!first_word) begin
				push_char(bwmf_pkg::SPACE_CHAR);
			end
			first_word = 0;
			for (int i = 0; i < word_len; i++) begin
				push_char(hit ? bwmf_pkg::MASK_CHAR : word_buf[i]);
			end
			word_len = 0;
		endfunction

		function void note_input(logic [1:0] c, logic [7:0] d, logic l);
			bwmf_pkg::out_item_t it;
			bit full;
			n_in++;
			case (c)
				bwmf_pkg::CMD_CLEAR: begin
					pat_cnt = 0;
					load_len = 0;
				end
				bwmf_pkg::CMD_PATTERN: begin
					full = pat_cnt >= NPAT;
					if (d != 8'h00) begin
						if (full || load_len >= PMAX) begin
							ovf_flag = 1;
						end else begin
							pat_mem[pat_cnt][load_len] = fold_case(d);
							load_len++;
						end
					end
					if (l) begin
						if (full) begin
							ovf_flag = 1;
						end else begin
							pat_len[pat_cnt] = load_len;
							pat_cnt++;
						end
						load_len = 0;
					end
				end
				bwmf_pkg::CMD_MESSAGE: begin
					if (d == bwmf_pkg::SPACE_CHAR) begin
						emit_word();
					end else if (d != 8'h00) begin
						if (word_len < WMAX) begin
							word_buf[word_len] = d;
							word_len++;
						end else begin
							ovf_flag = 1;
						end
					end
					if (l) begin
						emit_word();
						it = '0;
						it.end_of_message = 1'b1;
						it.banned_found = banned_flag;
						it.overflow_flag = ovf_flag;
						expected_q.push_back(it);
						first_word = 1;
						banned_flag = 0;
						ovf_flag = 0;
						word_len = 0;
						n_msgs++;
					end
				end
				default: begin
				end
			endcase
		endfunction

		function string check(bwmf_pkg::out_item_t got);
			bwmf_pkg::out_item_t want;
			n_out++;
			if (expected_q.size() == 0) begin
				return $sformatf("unexpected output item %h", got);
			end
			want = expected_q.pop_front();
			if (got.out_char != want.out_char || got.char_valid != want.char_valid ||
					got.end_of_message != want.end_of_message ||
					got.banned_found != want.banned_found ||
					got.overflow_flag != want.overflow_flag) begin
				return $sformatf("item %0d got char %h v%b e%b b%b o%b want char %h v%b e%b b%b o%b",
					n_out, got.out_char, got.char_valid, got.end_of_message,
					got.banned_found, got.overflow_flag, want.out_char, want.char_valid,
					want.end_of_message, want.banned_found, want.overflow_flag);
			end
			return "";
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	int errors;
	mask_scoreboard sb;

	bwmf_in_if in_ch();
	bwmf_out_if out_ch();

	banned_word_masking_filter_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #2 clk = ~clk;

	initial begin
		#10000000;
		$display("timeout");
		$display("banned_word_masking_filter_top verification failed");
		$finish;
	end

	task automatic report_mismatch(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	// monitors sample between edges, handshakes are stable there
	always @(negedge clk) begin
		bwmf_pkg::out_item_t got;
		string msg;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(in_ch.cmd, in_ch.data_byte, in_ch.last_byte);
			end
			if (out_ch.valid && out_ch.ready) begin
				got.out_char = out_ch.out_char;
				got.char_valid = out_ch.char_valid;
				got.end_of_message = out_ch.end_of_message;
				got.banned_found = out_ch.banned_found;
				got.overflow_flag = out_ch.overflow_flag;
				msg = sb.check(got);
				if (msg != "") begin
					report_mismatch(msg);
				end
			end
		end
	end

	function automatic int pick_gap();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// output side stall
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
				@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(negedge clk); while (!out_ch.valid);
		end
	end

	task automatic send(logic [1:0] c, logic [7:0] d, logic l);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.data_byte <= d;
		in_ch.last_byte <= l;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
	endtask

	task automatic load_pattern(string s);
		if (s.len() == 0) begin
			send(bwmf_pkg::CMD_PATTERN, 8'h00, 1'b1);
		end
		for (int i = 0; i < s.len(); i++) begin
			send(bwmf_pkg::CMD_PATTERN, s[i], i == s.len() - 1);
		end
	endtask

	function automatic logic [7:0] rand_char();
		logic [7:0] alpha[6] = '{8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h5A};
		return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: alpha[$urandom_range(0, 5)];
	endfunction

	task automatic rand_pattern();
		int n;
		n = ($urandom_range(0, 15) == 0) ? 34 : $urandom_range(0, 3);
		if (n == 0) begin
			send(bwmf_pkg::CMD_PATTERN, 8'h00, 1'b1);
		end
		for (int i = 0; i < n; i++) begin
			send(bwmf_pkg::CMD_PATTERN, rand_char(), i == n - 1);
		end
	endtask

	task automatic rand_message();
		int words;
		int wl;
		int sp;
		words = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) begin
			send(bwmf_pkg::CMD_MESSAGE, bwmf_pkg::SPACE_CHAR, 1'b0);
		end
		for (int w = 0; w < words; w++) begin
			wl = ($urandom_range(0, 19) == 0) ? 35 : $urandom_range(1, 5);
			for (int i = 0; i < wl; i++) begin
				send(bwmf_pkg::CMD_MESSAGE, rand_char(), 1'b0);
			end
			sp = $urandom_range(1, 3);
			for (int i = 0; i < sp; i++) begin
				send(bwmf_pkg::CMD_MESSAGE, bwmf_pkg::SPACE_CHAR, 1'b0);
			end
		end
		case ($urandom_range(0, 2))
			0: send(bwmf_pkg::CMD_MESSAGE, bwmf_pkg::SPACE_CHAR, 1'b1);
			1: send(bwmf_pkg::CMD_MESSAGE, 8'h00, 1'b1);
			default: send(bwmf_pkg::CMD_MESSAGE, rand_char(), 1'b1);
		endcase
	endtask

	initial begin
		int r;
		sb = new();
		errors = 0;
		calm = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = bwmf_pkg::CMD_CLEAR;
		in_ch.data_byte = 8'h00;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: case folding, space runs, zero bytes, empty pattern
		send(bwmf_pkg::CMD_CLEAR, 8'hFF, 1'b1);
		load_pattern("aB");
		send(CMD_UNUSED, 8'hFF, 1'b1);
		send(bwmf_pkg::CMD_MESSAGE, "x", 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, "A", 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, "b", 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, bwmf_pkg::SPACE_CHAR, 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, bwmf_pkg::SPACE_CHAR, 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, "Z", 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, 8'h00, 1'b1);
		load_pattern("");
		send(bwmf_pkg::CMD_MESSAGE, 8'hFF, 1'b1);
		send(bwmf_pkg::CMD_CLEAR, 8'h00, 1'b0);
		send(bwmf_pkg::CMD_MESSAGE, bwmf_pkg::SPACE_CHAR, 1'b1);
		send(bwmf_pkg::CMD_MESSAGE, 8'h00, 1'b1);

		// table full: one-char patterns past the table size
		calm = 1;
		for (int i = 0; i < NPAT + 2; i++) begin
			send(bwmf_pkg::CMD_PATTERN, 8'($urandom_range(8'h61, 8'h7A)), 1'b1);
		end
		calm = 0;
		rand_message();
		send(bwmf_pkg::CMD_CLEAR, 8'h00, 1'b0);

		while (sb.n_in < 300) begin
			if (sb.n_in % 60 < 15) begin
				calm = 1;
			end else begin
				calm = 0;
			end
			r = $urandom_range(0, 99);
			if (r < 8 || sb.pat_cnt > 8) begin
				send(bwmf_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end else if (r < 33) begin
				rand_pattern();
			end else if (r < 36) begin
				send(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				rand_message();
			end
		end
		send(bwmf_pkg::CMD_MESSAGE, "q", 1'b1);
		in_ch.valid <= 1'b0;

		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (300) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected items never arrived",
				sb.expected_q.size()));
		end
		$display("run covered %0d input items, %0d messages, %0d masked words",
			sb.n_in, sb.n_msgs, sb.n_masked);
		$display("%0d output items checked, %0d mismatches", sb.n_out, errors);
		if (errors == 0) begin
			$display("banned_word_masking_filter_top verification clean");
		end else begin
			$display("banned_word_masking_filter_top verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
